// ===== src/eed_pkg.sv =====
`timescale 1ns / 1ps
// eed_pkg: types and constants for the echo escape decoder
// no dependencies; imported by echo_escape_decoder_top

package eed_pkg;

   localparam int ByteW = 8;
   localparam int MaxResults = 3;

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_ESCAPE = 2'd1,
      PH_OCTAL  = 2'd2,
      PH_HEX    = 2'd3
   } phase_type;

   localparam logic [ByteW-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [ByteW-1:0] CH_ZERO      = 8'h30;
   localparam logic [ByteW-1:0] CH_X         = 8'h78;
   localparam logic [ByteW-1:0] CH_A         = 8'h61;
   localparam logic [ByteW-1:0] CH_B         = 8'h62;
   localparam logic [ByteW-1:0] CH_C         = 8'h63;
   localparam logic [ByteW-1:0] CH_E         = 8'h65;
   localparam logic [ByteW-1:0] CH_F         = 8'h66;
   localparam logic [ByteW-1:0] CH_N         = 8'h6E;
   localparam logic [ByteW-1:0] CH_T         = 8'h74;
   localparam logic [ByteW-1:0] CH_V         = 8'h76;

   localparam logic [ByteW-1:0] CODE_BEL = 8'd7;
   localparam logic [ByteW-1:0] CODE_BS  = 8'd8;
   localparam logic [ByteW-1:0] CODE_ESC = 8'd27;
   localparam logic [ByteW-1:0] CODE_FF  = 8'd12;
   localparam logic [ByteW-1:0] CODE_LF  = 8'd10;
   localparam logic [ByteW-1:0] CODE_HT  = 8'd9;
   localparam logic [ByteW-1:0] CODE_VT  = 8'd11;

   localparam logic [1:0] OctMaxDigits = 2'd3;
   localparam logic [1:0] HexMaxDigits = 2'd2;

   // up to three result bytes waiting for the output side
   typedef struct packed {
      logic [MaxResults-1:0][ByteW-1:0] bytes;
      logic [1:0]                       count;
   } res_queue_type;

   function automatic res_queue_type push(res_queue_type q, logic [ByteW-1:0] v);
      res_queue_type r;
      r = q;
      if (q.count != 2'd3) begin
         r.bytes[q.count] = v;
         r.count = q.count + 2'd1;
      end
      return r;
   endfunction

endpackage

// ===== src/echo_escape_decoder_top.sv =====
`timescale 1ns / 1ps
// echo_escape_decoder_top: backslash escape decoder for one echo argument
// depends on eed_pkg
//
// output: the first result of a byte is registered and shown in the cycle after its beat is taken
// throughput: one input beat per cycle while each byte gives at most one result
//   and the output is ready; a byte giving several results holds the input while
//   the result register drains one beat per cycle in which the output is ready
// reset: synchronous; escapes off, decoder in normal text, result register empty

module echo_escape_decoder_top (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,   // escapes_enabled
   // input stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] in_byte
   input  logic       req_tlast,     // end_of_text
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic       rsp_tlast      // last_of_run
);
   import eed_pkg::*;

   logic          esc_en_ff;
   phase_type     phase_ff, phase_in;
   logic [7:0]    acc_ff, acc_in;
   logic [1:0]    dcnt_ff, dcnt_in;
   logic          stop_ff, stop_in;
   res_queue_type q_ff, q_in, q_new;

   logic          req_fire, rsp_fire;
   logic [7:0]    b;
   logic          oct_ok, hex_ok, dig_ok;
   logic [3:0]    dig_val;
   logic [7:0]    acc_next;
   logic [1:0]    dcnt_next;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign b = req_tdata;

   // digit decode for the current byte
   always_comb begin
      oct_ok  = (b >= 8'h30) && (b <= 8'h37);
      hex_ok  = 1'b0;
      dig_val = 4'd0;
      if ((b >= 8'h30) && (b <= 8'h39)) begin
         hex_ok  = 1'b1;
         dig_val = 4'(b - 8'h30);
      end else if ((b >= 8'h61) && (b <= 8'h66)) begin
         hex_ok  = 1'b1;
         dig_val = 4'(b - 8'h57);
      end else if ((b >= 8'h41) && (b <= 8'h46)) begin
         hex_ok  = 1'b1;
         dig_val = 4'(b - 8'h37);
      end
      dig_ok = (phase_ff == PH_OCTAL) ? oct_ok : hex_ok;
      if (phase_ff == PH_OCTAL) begin
         acc_next = {acc_ff[4:0], 3'b000} | {5'd0, dig_val[2:0]};
      end else begin
         acc_next = {acc_ff[3:0], dig_val};
      end
      dcnt_next = dcnt_ff + 2'd1;
   end

   // decode one byte into up to three results and the next decoder state
   always_comb begin
      q_new    = '0;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      dcnt_in  = dcnt_ff;
      stop_in  = stop_ff;

      if (!esc_en_ff) begin
         q_new = push(q_new, b);
      end else begin
         if (!stop_ff) begin
            case (phase_ff)
               PH_NORMAL: begin
                  if (b == CH_BACKSLASH) phase_in = PH_ESCAPE;
                  else                   q_new = push(q_new, b);
               end
               PH_ESCAPE: begin
                  phase_in = PH_NORMAL;
                  case (b)
                     CH_A:         q_new = push(q_new, CODE_BEL);
                     CH_B:         q_new = push(q_new, CODE_BS);
                     CH_E:         q_new = push(q_new, CODE_ESC);
                     CH_F:         q_new = push(q_new, CODE_FF);
                     CH_N:         q_new = push(q_new, CODE_LF);
                     CH_T:         q_new = push(q_new, CODE_HT);
                     CH_V:         q_new = push(q_new, CODE_VT);
                     CH_BACKSLASH: q_new = push(q_new, CH_BACKSLASH);
                     CH_C:         stop_in = 1'b1;
                     CH_ZERO: begin
                        phase_in = PH_OCTAL;
                        acc_in   = '0;
                        dcnt_in  = '0;
                     end
                     CH_X: begin
                        phase_in = PH_HEX;
                        acc_in   = '0;
                        dcnt_in  = '0;
                     end
                     default: begin
                        q_new = push(q_new, CH_BACKSLASH);
                        q_new = push(q_new, b);
                     end
                  endcase
               end
               default: begin
                  if (dig_ok) begin
                     if (dcnt_next == ((phase_ff == PH_OCTAL) ? OctMaxDigits : HexMaxDigits)) begin
                        q_new    = push(q_new, acc_next);
                        phase_in = PH_NORMAL;
                        acc_in   = '0;
                        dcnt_in  = '0;
                     end else begin
                        acc_in  = acc_next;
                        dcnt_in = dcnt_next;
                     end
                  end else begin
                     // sequence ended by a non-digit: flush, then treat as text
                     if (dcnt_ff == 2'd0) begin
                        q_new = push(q_new, CH_BACKSLASH);
                        q_new = push(q_new, (phase_ff == PH_OCTAL) ? CH_ZERO : CH_X);
                     end else begin
                        q_new = push(q_new, acc_ff);
                     end
                     acc_in  = '0;
                     dcnt_in = '0;
                     if (b == CH_BACKSLASH) begin
                        phase_in = PH_ESCAPE;
                     end else begin
                        phase_in = PH_NORMAL;
                        q_new    = push(q_new, b);
                     end
                  end
               end
            endcase
         end
         // end of text flushes what is still pending
         if (req_tlast && !stop_in) begin
            case (phase_in)
               PH_ESCAPE: q_new = push(q_new, CH_BACKSLASH);
               PH_OCTAL, PH_HEX: begin
                  if (dcnt_in == 2'd0) begin
                     q_new = push(q_new, CH_BACKSLASH);
                     q_new = push(q_new, (phase_in == PH_OCTAL) ? CH_ZERO : CH_X);
                  end else begin
                     q_new = push(q_new, acc_in);
                  end
               end
               default: ;
            endcase
         end
      end

      if (req_tlast) begin
         phase_in = PH_NORMAL;
         acc_in   = '0;
         dcnt_in  = '0;
         stop_in  = 1'b0;
      end
   end

   // result register: shifts one beat out per accepted output
   assign req_tready = (q_ff.count == 2'd0) || ((q_ff.count == 2'd1) && rsp_tready);
   assign rsp_tvalid = (q_ff.count != 2'd0);
   assign rsp_tdata  = q_ff.bytes[0];
   assign rsp_tlast  = (q_ff.count == 2'd1);

   always_comb begin
      q_in = q_ff;
      if (req_fire) begin
         q_in = q_new;
      end else if (rsp_fire) begin
         q_in.bytes[0] = q_ff.bytes[1];
         q_in.bytes[1] = q_ff.bytes[2];
         q_in.count    = q_ff.count - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_en_ff <= 1'b0;
         phase_ff  <= PH_NORMAL;
         acc_ff    <= '0;
         dcnt_ff   <= '0;
         stop_ff   <= 1'b0;
         q_ff      <= '0;
      end else begin
         if (csr_wr_en) esc_en_ff <= csr_wr_data;
         if (req_fire) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            dcnt_ff  <= dcnt_in;
            stop_ff  <= stop_in;
         end
         q_ff <= q_in;
      end
   end

   a_pass_one: assert property (@(posedge clock) disable iff (reset)
      req_fire && !esc_en_ff && !csr_wr_en |=> q_ff.count == 2'd1)
      else $error("pass-through byte did not give exactly one beat");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> phase_ff == PH_NORMAL && !stop_ff && dcnt_ff == 2'd0)
      else $error("decoder state not cleared after end of text");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      q_ff.count > 2'd1 |-> !req_tready)
      else $error("input taken while several result beats still pending");

   a_stop_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && esc_en_ff && stop_ff && !req_tlast |=> q_ff.count == 2'd0)
      else $error("output produced while stopped");

endmodule
